@@ hdl/aqgf_pkg.sv @@
package aqgf_pkg;

  localparam int QUEUE_DEPTH  = 4096;
  localparam int MAX_CHANNELS = 8;

  localparam int ADDR_W   = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W  = ADDR_W + 1;
  localparam int CPOS_W   = 3;
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 17;
  localparam int CHAN_W   = 4;
  localparam int FADE_W   = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = 4;

  localparam logic [GAIN_W-1:0]   UNITY_GAIN  = 17'h10000;
  localparam logic [CHAN_W-1:0]   CHAN_MAX    = CHAN_W'(MAX_CHANNELS);
  localparam logic [SAMPLE_W-1:0] SAT_NEG_MAG = 16'h8000;
  localparam logic [SAMPLE_W-1:0] SAT_POS     = 16'h7fff;

  localparam logic [GAIN_W-1:0] GAIN_RESET     = 17'h10000;
  localparam logic [CHAN_W-1:0] CHANNELS_RESET = 4'd2;
  localparam logic [FADE_W-1:0] FADE_LEN_RESET = 16'd1920;

  localparam logic [1:0] FUNC_PUSH = 2'd0;
  localparam logic [1:0] FUNC_PULL = 2'd1;
  localparam logic [1:0] FUNC_STOP = 2'd2;
  localparam logic [1:0] FUNC_FADE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_LEN = 2'd2;

  typedef struct packed {
    logic [1:0]                 func;
    logic signed [SAMPLE_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_sample;
    logic                       out_valid;
    logic                       pending;
    logic                       dropped;
    logic                       fading;
  } result_t;

  typedef struct packed {
    logic accept;
    logic mul1;
    logic mul2;
    logic div_load;
    logic div_frames;
    logic div_step;
    logic frames_apply;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic scale_path;
    logic frames_path;
    logic out_free;
  } status_t;

endpackage

@@ hdl/aqgf_ctrl.sv @@
module aqgf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  aqgf_pkg::status_t st,
  output aqgf_pkg::cmd_t    cmd
);
  import aqgf_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MUL1   = 7'b0000010,
    S_MUL2   = 7'b0000100,
    S_DIVLD  = 7'b0001000,
    S_DIV    = 7'b0010000,
    S_FRAMES = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t               state, state_next;
  logic [DIV_CNT_W-1:0] cnt, cnt_next;
  logic                 frames, frames_next;

  assign item_stall = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    frames_next = frames;
    cmd         = '0;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.accept = 1'b1;
          if (st.scale_path) begin
            frames_next = 1'b0;
            state_next  = S_MUL1;
          end else if (st.frames_path) begin
            frames_next = 1'b1;
            state_next  = S_DIVLD;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_DIVLD;
      end
      S_DIVLD: begin
        cmd.div_load   = 1'b1;
        cmd.div_frames = frames;
        cnt_next       = '0;
        state_next     = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = frames ? S_FRAMES : S_FINISH;
        end
      end
      S_FRAMES: begin
        cmd.frames_apply = 1'b1;
        state_next       = S_FINISH;
      end
      S_FINISH: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      frames <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      frames <= frames_next;
    end
  end

endmodule

@@ hdl/aqgf_dp.sv @@
module aqgf_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  aqgf_pkg::item_t                     item,
  input  logic                                cfg_we,
  input  logic [aqgf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [aqgf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  aqgf_pkg::cmd_t                      cmd,
  output aqgf_pkg::status_t                   st,
  output aqgf_pkg::result_t                   result,
  output logic                                result_valid,
  input  logic                                result_stall
);
  import aqgf_pkg::*;

  // configuration
  logic [GAIN_W-1:0] gain;
  logic [CHAN_W-1:0] channels;
  logic [FADE_W-1:0] fade_len;
  logic [GAIN_W-1:0] gain_eff;
  logic [CHAN_W-1:0] ch_eff;

  // queue state
  logic [ADDR_W-1:0]  rd_ptr, rd_ptr_next;
  logic [COUNT_W-1:0] count, count_next;
  logic [FADE_W-1:0]  fade_rem, fade_rem_next;
  logic [FADE_W-1:0]  fade_tot, fade_tot_next;
  logic [CPOS_W-1:0]  chan_pos, chan_pos_next;

  // sample store
  logic [SAMPLE_W-1:0] mem [QUEUE_DEPTH];
  logic [SAMPLE_W-1:0] mem_q;
  logic [ADDR_W-1:0]   wr_addr;
  logic                mem_we;

  // scaling datapath
  logic                neg;
  logic                zero;
  logic [FADE_W-1:0]   r_op;
  logic [FADE_W-1:0]   d_op;
  logic [SAMPLE_W-1:0] mag;
  logic [32:0]         prod1;
  logic [31:0]         p;
  logic [47:0]         num;
  logic [47:0]         sum48;

  // shared divider
  logic [15:0] rem;
  logic [15:0] mlo;
  logic [15:0] quo;
  logic [15:0] div_d;
  logic [16:0] trial;
  logic [16:0] trial_diff;
  logic        trial_ge;

  // frame arithmetic
  logic [3:0]         cp_inc;
  logic               frame_end;
  logic [19:0]        left_full;
  logic [19:0]        left;
  logic [COUNT_W-1:0] trunc_count;
  logic [FADE_W-1:0]  frames_sel;
  logic [19:0]        frames_prod;

  // result assembly
  result_t             hold, hold_next;
  logic                hold_scaled, hold_scaled_next;
  logic [SAMPLE_W-1:0] q_sat;
  logic [SAMPLE_W-1:0] final_sample;
  logic                drop;
  logic                vld;
  logic                scaled;

  assign gain_eff = (gain > UNITY_GAIN) ? UNITY_GAIN : gain;
  assign ch_eff   = (channels == '0) ? CHAN_W'(1) :
                    (channels > CHAN_MAX) ? CHAN_MAX : channels;

  assign wr_addr = rd_ptr + count[ADDR_W-1:0];
  assign mem_we  = cmd.accept && (item.func == FUNC_PUSH) && !count[COUNT_W-1];

  assign st.scale_path  = (item.func == FUNC_PULL) && (count != '0);
  assign st.frames_path = (item.func == FUNC_FADE) && (count != '0) && (fade_rem == '0);
  assign st.out_free    = !result_valid || !result_stall;

  assign mag   = mem_q[SAMPLE_W-1] ? (SAMPLE_W'(0) - mem_q) : mem_q;
  assign prod1 = {17'd0, mag} * {16'd0, gain_eff};
  // round half away: add half the divisor before the floor division
  assign sum48 = num + {17'd0, d_op, 15'd0};

  assign trial      = {rem, mlo[15]};
  assign trial_ge   = trial >= {1'b0, div_d};
  assign trial_diff = trial - {1'b0, div_d};

  assign cp_inc    = {1'b0, chan_pos} + 4'd1;
  assign frame_end = cp_inc >= ch_eff;
  assign left_full = {4'd0, fade_rem} * {16'd0, ch_eff};
  assign left      = (left_full > {17'd0, chan_pos}) ? (left_full - {17'd0, chan_pos}) : '0;
  assign trunc_count = (left < {7'd0, count}) ? left[COUNT_W-1:0] : count;
  assign frames_sel  = (quo > fade_len) ? fade_len : quo;
  assign frames_prod = {4'd0, frames_sel} * {16'd0, ch_eff};

  always_comb begin
    rd_ptr_next   = rd_ptr;
    count_next    = count;
    fade_rem_next = fade_rem;
    fade_tot_next = fade_tot;
    chan_pos_next = chan_pos;
    drop          = 1'b0;
    vld           = 1'b0;
    scaled        = 1'b0;
    if (cmd.accept) begin
      case (item.func)
        FUNC_PUSH: begin
          if (count[COUNT_W-1]) begin
            drop = 1'b1;
          end else begin
            count_next = count + COUNT_W'(1);
          end
        end
        FUNC_PULL: begin
          if (count != '0) begin
            vld         = 1'b1;
            scaled      = 1'b1;
            rd_ptr_next = rd_ptr + ADDR_W'(1);
            count_next  = count - COUNT_W'(1);
            if (fade_rem != '0) begin
              if (frame_end) begin
                chan_pos_next = '0;
                fade_rem_next = fade_rem - FADE_W'(1);
                if (fade_rem == FADE_W'(1)) begin
                  fade_tot_next = '0;
                end
              end else begin
                chan_pos_next = cp_inc[CPOS_W-1:0];
              end
            end
            // drained queue ends any fade
            if (count == COUNT_W'(1)) begin
              rd_ptr_next   = '0;
              fade_rem_next = '0;
              fade_tot_next = '0;
              chan_pos_next = '0;
            end
          end
        end
        FUNC_STOP: begin
          rd_ptr_next   = '0;
          count_next    = '0;
          fade_rem_next = '0;
          fade_tot_next = '0;
          chan_pos_next = '0;
        end
        default: begin
          if (count == '0) begin
            rd_ptr_next   = '0;
            fade_rem_next = '0;
            fade_tot_next = '0;
            chan_pos_next = '0;
          end else if (fade_rem != '0) begin
            // fade already running: cut the queue to what it still covers
            count_next = trunc_count;
            if (trunc_count == '0) begin
              rd_ptr_next   = '0;
              fade_rem_next = '0;
              fade_tot_next = '0;
              chan_pos_next = '0;
            end
          end
        end
      endcase
    end else if (cmd.frames_apply) begin
      if (frames_sel != '0) begin
        count_next    = frames_prod[COUNT_W-1:0];
        fade_rem_next = frames_sel;
        fade_tot_next = frames_sel;
        chan_pos_next = '0;
      end else begin
        rd_ptr_next   = '0;
        count_next    = '0;
        fade_rem_next = '0;
        fade_tot_next = '0;
        chan_pos_next = '0;
      end
    end
  end

  always_comb begin
    hold_next        = hold;
    hold_scaled_next = hold_scaled;
    if (cmd.accept || cmd.frames_apply) begin
      hold_next.out_sample = '0;
      hold_next.out_valid  = vld;
      hold_next.pending    = (count_next != '0);
      hold_next.dropped    = drop;
      hold_next.fading     = (fade_rem_next != '0);
      hold_scaled_next     = scaled;
    end
  end

  always_comb begin
    if (neg) begin
      q_sat        = (quo > SAT_NEG_MAG) ? SAT_NEG_MAG : quo;
      final_sample = SAMPLE_W'(0) - q_sat;
    end else begin
      q_sat        = (quo > SAT_POS) ? SAT_POS : quo;
      final_sample = q_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= item.sample;
    end
    if (cmd.accept) begin
      mem_q <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain         <= GAIN_RESET;
      channels     <= CHANNELS_RESET;
      fade_len     <= FADE_LEN_RESET;
      rd_ptr       <= '0;
      count        <= '0;
      fade_rem     <= '0;
      fade_tot     <= '0;
      chan_pos     <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GAIN:     gain     <= cfg_data;
          CFG_CHANNELS: channels <= cfg_data[CHAN_W-1:0];
          CFG_FADE_LEN: fade_len <= cfg_data[FADE_W-1:0];
          default: begin
          end
        endcase
      end
      rd_ptr   <= rd_ptr_next;
      count    <= count_next;
      fade_rem <= fade_rem_next;
      fade_tot <= fade_tot_next;
      chan_pos <= chan_pos_next;
      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    hold        <= hold_next;
    hold_scaled <= hold_scaled_next;
    if (cmd.accept && (item.func == FUNC_PULL)) begin
      // plain gain runs the same path with a unit envelope
      if (fade_rem != '0) begin
        zero <= (fade_tot <= FADE_W'(1));
        r_op <= fade_rem - FADE_W'(1);
        d_op <= (fade_tot > FADE_W'(1)) ? (fade_tot - FADE_W'(1)) : FADE_W'(1);
      end else begin
        zero <= 1'b0;
        r_op <= FADE_W'(1);
        d_op <= FADE_W'(1);
      end
    end
    if (cmd.mul1) begin
      neg <= mem_q[SAMPLE_W-1];
      p   <= prod1[31:0];
    end
    if (cmd.mul2) begin
      num <= {16'd0, p} * {32'd0, r_op};
    end
    if (cmd.div_load) begin
      if (cmd.div_frames) begin
        rem   <= '0;
        mlo   <= {3'd0, count};
        div_d <= {12'd0, ch_eff};
      end else begin
        rem   <= sum48[47:32];
        mlo   <= sum48[31:16];
        div_d <= d_op;
      end
    end else if (cmd.div_step) begin
      rem <= trial_ge ? trial_diff[15:0] : trial[15:0];
      mlo <= {mlo[14:0], 1'b0};
      quo <= {quo[14:0], trial_ge};
    end
    if (cmd.load_out) begin
      result <= '{out_sample: (hold_scaled && !zero) ? final_sample : SAMPLE_W'(0),
                  out_valid:  hold.out_valid,
                  pending:    hold.pending,
                  dropped:    hold.dropped,
                  fading:     hold.fading};
    end
  end

endmodule

@@ hdl/audio_queue_gain_fade_out.sv @@
// Playback queue of interleaved 16-bit samples with gain and linear fade-out.
// Input channel item_valid / item_stall / item carries a function code and a
// sample: push, pull, stop immediately, stop with fade. Every transaction
// yields exactly one result on result_valid / result_stall / result.
// Push, stop, and a pull of an empty queue go straight to the output stage,
// which loads the output register once it is free. Pull of a queued sample:
// the two multiplier stages and a 16-step restoring divider apply gain and
// envelope. First stop-with-fade: the same divider splits the queue into
// frames. One item is worked on at a time; item_stall is high from the
// transaction until its result enters the output register, so the next item
// can follow in the cycle after that. The output register holds the result
// while result_stall is high; the next item is taken meanwhile, but its
// result waits until the register frees. Configuration (cfg_we, cfg_index,
// cfg_data) is to be written by the user only while idle; the block does not
// enforce this. Synchronous reset empties the queue, ends any fade, loads gain
// unity, two channels and a 1920-frame fade length; store is not cleared.
module audio_queue_gain_fade_out (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  aqgf_pkg::item_t                 item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output aqgf_pkg::result_t               result,
  input  logic                            cfg_we,
  input  logic [aqgf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [aqgf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import aqgf_pkg::*;

  cmd_t    cmd;
  status_t st;

  aqgf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .st         (st),
    .cmd        (cmd)
  );

  aqgf_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .st           (st),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule

@@ test/tb_audio_queue_gain_fade_out.sv @@
`timescale 1ns / 1ps

module tb_audio_queue_gain_fade_out;
  import aqgf_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int ITEM_TARGET    = 1980;
  localparam int DRAIN_CYCLES   = 30;

  class playback_scoreboard;
    logic signed [SAMPLE_W-1:0] store [QUEUE_DEPTH];
    int unsigned rd_ptr   = 0;
    int unsigned count    = 0;
    int unsigned fade_rem = 0;
    int unsigned fade_tot = 0;
    int unsigned cpos     = 0;
    int unsigned gain     = GAIN_RESET;
    int unsigned channels = CHANNELS_RESET;
    int unsigned fade_len = FADE_LEN_RESET;
    int unsigned errors   = 0;
    result_t expected_results[$];

    function void clear_queue();
      rd_ptr   = 0;
      count    = 0;
      fade_rem = 0;
      fade_tot = 0;
      cpos     = 0;
    endfunction

    function int unsigned eff_channels();
      if (channels == 0) return 1;
      if (channels > MAX_CHANNELS) return MAX_CHANNELS;
      return channels;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_GAIN:     gain = val;
        CFG_CHANNELS: channels = val[CHAN_W-1:0];
        CFG_FADE_LEN: fade_len = val[FADE_W-1:0];
        default: ;
      endcase
    endfunction

    // gain and envelope as one exact ratio, rounded half away from zero
    function logic [SAMPLE_W-1:0] scaled(logic signed [SAMPLE_W-1:0] s);
      longint unsigned mag, g, num, den, q;
      bit neg;
      neg = s[SAMPLE_W-1];
      mag = neg ? -int'(s) : int'(s);
      g   = (gain > UNITY_GAIN) ? UNITY_GAIN : gain;
      if (fade_rem != 0) begin
        if (fade_tot <= 1) return '0;
        num = mag * g * 64'(fade_rem - 1);
        den = 64'(UNITY_GAIN) * 64'(fade_tot - 1);
      end else begin
        num = mag * g;
        den = 64'(UNITY_GAIN);
      end
      q = (2 * num + den) / (2 * den);
      if (neg) begin
        if (q > 32768) q = 32768;
        return SAMPLE_W'(-q);
      end
      if (q > 32767) q = 32767;
      return SAMPLE_W'(q);
    endfunction

    function result_t playback_result(item_t it);
      result_t res;
      int unsigned ch, left, frames;
      bit done;
      res  = '0;
      ch   = eff_channels();
      done = 0;
      case (it.func)
        FUNC_PUSH: begin
          if (count >= QUEUE_DEPTH) begin
            res.dropped = 1'b1;
          end else begin
            store[(rd_ptr + count) % QUEUE_DEPTH] = it.sample;
            count++;
          end
        end
        FUNC_PULL: begin
          if (count != 0) begin
            res.out_sample = scaled(store[rd_ptr]);
            res.out_valid  = 1'b1;
            rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH;
            count--;
            if (fade_rem != 0) begin
              cpos++;
              if (cpos >= ch) begin
                cpos = 0;
                fade_rem--;
                if (fade_rem == 0) fade_tot = 0;
              end
            end
            if (count == 0) clear_queue();
          end
        end
        FUNC_STOP: clear_queue();
        FUNC_FADE: begin
          if (count != 0) begin
            if (fade_rem != 0) begin
              // fade already running: cut back to what it still covers
              left = fade_rem * ch;
              left = (left > cpos) ? left - cpos : 0;
              if (left < count) count = left;
              if (count == 0) clear_queue();
              done = 1;
            end else begin
              frames = count / ch;
              if (frames > fade_len) frames = fade_len;
              if (frames != 0) begin
                count    = frames * ch;
                fade_rem = frames;
                fade_tot = frames;
                cpos     = 0;
                done     = 1;
              end
            end
          end
          if (!done) clear_queue();
        end
        default: ;
      endcase
      res.pending = (count != 0);
      res.fading  = (fade_rem != 0);
      return res;
    endfunction

    function void note_item(item_t it);
      expected_results.push_back(playback_result(it));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $error("unexpected result: out_sample %0d out_valid %0b", got.out_sample, got.out_valid);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.out_sample !== want.out_sample) begin
        $error("out_sample expected %0d got %0d", want.out_sample, got.out_sample);
        errors++;
      end
      if (got.out_valid !== want.out_valid) begin
        $error("out_valid expected %0b got %0b", want.out_valid, got.out_valid);
        errors++;
      end
      if (got.pending !== want.pending) begin
        $error("pending expected %0b got %0b", want.pending, got.pending);
        errors++;
      end
      if (got.dropped !== want.dropped) begin
        $error("dropped expected %0b got %0b", want.dropped, got.dropped);
        errors++;
      end
      if (got.fading !== want.fading) begin
        $error("fading expected %0b got %0b", want.fading, got.fading);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  item_valid;
  logic                  item_stall;
  item_t                 item;
  logic                  result_valid;
  logic                  result_stall;
  result_t               result;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  playback_scoreboard sb;
  bit          no_idle     = 0;
  bit          rx_taken    = 0;
  int unsigned rx_wait     = 0;
  int unsigned items_sent  = 0;
  int unsigned stuck_count = 0;

  always #4 clk = ~clk;

  audio_queue_gain_fade_out dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  function automatic int unsigned draw_wait();
    return no_idle ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 11))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return -16'sd1;
      4: return 16'sd1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return UNITY_GAIN;
      2: return 17'h1ffff;
      3: return CFG_DATA_W'($urandom_range(65537, 131071));
      4: return CFG_DATA_W'($urandom_range(1, 255));
      default: return CFG_DATA_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_fade_len();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 17'd65535;
      2: return CFG_DATA_W'($urandom_range(0, 65535));
      default: return CFG_DATA_W'($urandom_range(1, 8));
    endcase
  endfunction

  // result side: a fresh stall length after each transaction
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      sb.check_result(result);
      rx_taken = 1;
    end
  end

  always @(negedge clk) begin
    if (rx_taken) begin
      rx_taken = 0;
      rx_wait  = draw_wait();
    end
    result_stall <= (rx_wait != 0);
    if (rx_wait != 0) rx_wait--;
  end

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) stuck_count = 0;
    else stuck_count++;
    if (stuck_count >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] f, logic signed [SAMPLE_W-1:0] smp);
    int unsigned wait_n;
    wait_n = draw_wait();
    if (wait_n != 0) begin
      @(negedge clk);
      item_valid <= 1'b0;
      repeat (wait_n - 1) @(negedge clk);
    end
    @(negedge clk);
    item_valid <= 1'b1;
    item       <= item_t'{func: f, sample: smp};
    do @(posedge clk); while (item_stall);
    sb.note_item(item_t'{func: f, sample: smp});
    items_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    item_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic push_burst(int unsigned n);
    repeat (n) send_item(FUNC_PUSH, pick_sample());
  endtask

  task automatic pull_burst(int unsigned n);
    repeat (n) send_item(FUNC_PULL, pick_sample());
  endtask

  task automatic fade_episode();
    int unsigned ch;
    ch = sb.eff_channels();
    push_burst($urandom_range(1, 6) * ch + $urandom_range(0, ch));
    send_item(FUNC_FADE, pick_sample());
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 5))
        0: push_burst($urandom_range(1, 4));
        1: send_item(FUNC_FADE, pick_sample());
        default: pull_burst($urandom_range(1, 2 * ch));
      endcase
    end
    // sometimes leave the fade running into the next phase
    if ($urandom_range(0, 3) != 0) pull_burst(sb.count + $urandom_range(0, 1));
  endtask

  task automatic episode();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 6) begin
      push_burst($urandom_range(1, 24));
    end else if (r < 10) begin
      pull_burst($urandom_range(1, sb.count + 4));
    end else if (r < 16) begin
      fade_episode();
    end else if (r < 18) begin
      push_burst($urandom_range(0, 5));
      send_item(FUNC_STOP, pick_sample());
    end else begin
      repeat ($urandom_range(1, 10)) send_item(2'($urandom_range(0, 3)), pick_sample());
    end
  endtask

  task automatic start_phase(int unsigned p);
    logic [CFG_DATA_W-1:0] g, c, fl;
    settle();
    if (p < 5) begin
      case (p)
        0: begin g = '0;         c = 0;  fl = 0;     end
        1: begin g = 17'h1ffff;  c = 15; fl = 65535; end
        2: begin g = 65537;      c = 9;  fl = 1;     end
        3: begin g = 1;          c = 1;  fl = 2;     end
        default: begin g = UNITY_GAIN; c = 8; fl = 3; end
      endcase
      program_reg(CFG_GAIN, g);
      program_reg(CFG_CHANNELS, c);
      program_reg(CFG_FADE_LEN, fl);
    end else begin
      if ($urandom_range(0, 1)) program_reg(CFG_GAIN, pick_gain());
      if ($urandom_range(0, 1)) begin
        c = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 15)) :
                                          CFG_DATA_W'($urandom_range(1, 8));
        program_reg(CFG_CHANNELS, c);
      end
      if ($urandom_range(0, 1)) program_reg(CFG_FADE_LEN, pick_fade_len());
    end
    no_idle = ($urandom_range(0, 4) == 0);
  endtask

  // fill past full, then wrap the pointers while partly drained
  task automatic overflow_run();
    int unsigned fill_n;
    fill_n = QUEUE_DEPTH + $urandom_range(1, 6);
    send_item(FUNC_STOP, pick_sample());
    no_idle = 1;
    push_burst(fill_n);
    no_idle = 0;
    items_sent -= fill_n;
    pull_burst($urandom_range(5, 20));
    push_burst($urandom_range(5, 25));
    send_item(FUNC_FADE, pick_sample());
    pull_burst($urandom_range(10, 40));
    send_item(FUNC_FADE, pick_sample());
    pull_burst($urandom_range(1, 10));
    send_item(FUNC_STOP, pick_sample());
  endtask

  initial begin
    int unsigned phase_no;
    bit          overflow_done;
    sb            = new;
    item_valid    = 1'b0;
    item          = '0;
    result_stall  = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    phase_no      = 0;
    overflow_done = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, at reset configuration
    send_item(FUNC_PULL, 16'sh7fff);
    send_item(FUNC_PUSH, 16'sh7fff);
    send_item(FUNC_PUSH, 16'sh8000);
    send_item(FUNC_PUSH, -16'sd1);
    send_item(FUNC_PUSH, 16'sd1);
    pull_burst(2);
    send_item(FUNC_FADE, 16'sh0000);   // single frame left: envelope is zero
    pull_burst(2);
    send_item(FUNC_PUSH, 16'sd5);
    send_item(FUNC_FADE, 16'sh0000);   // under one frame queued
    send_item(FUNC_PUSH, 16'sd100);
    send_item(FUNC_STOP, 16'sh0000);
    push_burst(6);
    send_item(FUNC_FADE, 16'sh0000);
    send_item(FUNC_PULL, 16'sh0000);
    send_item(FUNC_PUSH, 16'sd7);
    send_item(FUNC_FADE, 16'shffff);   // repeated fade cuts the late push
    pull_burst(5);

    while (items_sent < ITEM_TARGET) begin
      start_phase(phase_no);
      phase_no++;
      if (!overflow_done && items_sent > ITEM_TARGET / 2) begin
        overflow_run();
        overflow_done = 1;
      end
      repeat ($urandom_range(2, 6)) episode();
    end

    @(negedge clk);
    item_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/aqgf_pkg.sv
hdl/aqgf_ctrl.sv
hdl/aqgf_dp.sv
hdl/audio_queue_gain_fade_out.sv
test/tb_audio_queue_gain_fade_out.sv
